FILE: rtl/mips_subset_instruction_step_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef MIPS_SUBSET_INSTRUCTION_STEP_MACROS_SVH
`define MIPS_SUBSET_INSTRUCTION_STEP_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define MSIS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define MSIS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/msis_pkg.sv
`default_nettype none

package msis_pkg;

    // Byte memory address width; the memory holds 2**MSIS_MEM_AW bytes.
    localparam int unsigned MSIS_MEM_AW = 12;

    // Item kinds.
    localparam logic [2:0] FUNC_EXEC   = 3'd0;
    localparam logic [2:0] FUNC_WR_MEM = 3'd1;
    localparam logic [2:0] FUNC_RD_MEM = 3'd2;
    localparam logic [2:0] FUNC_WR_REG = 3'd3;
    localparam logic [2:0] FUNC_RD_REG = 3'd4;
    localparam logic [2:0] FUNC_SET_PC = 3'd5;

    // Opcodes.
    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;

    // R-type function codes.
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR  = 6'd37;
    localparam logic [5:0] FN_SLT = 6'd42;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic word;
    } mem_ctl_t;

    typedef struct packed {
        logic re;
        logic we;
    } rf_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/msis_bytemem.sv
`default_nettype none

module msis_bytemem
    import msis_pkg::*;
#(
    parameter int unsigned MEM_AW = MSIS_MEM_AW
) (
    input  wire logic              aclk,
    input  wire mem_ctl_t          ctl,
    input  wire logic [MEM_AW-1:0] addr,
    input  wire logic [31:0]       wdata,
    output logic      [31:0]       rdata
);

    localparam int unsigned ROW_W = MEM_AW - 2;
    localparam int unsigned ROWS  = 1 << ROW_W;

    logic [1:0] lane_reg;
    logic [7:0] bank_rd [4];

    // Four byte lanes; consecutive byte addresses always fall in distinct lanes,
    // so an unaligned word touches each lane exactly once.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0]        bank_mem [ROWS];
        logic [7:0]        q_reg;
        logic [1:0]        ofs;
        logic [MEM_AW-1:0] baddr;
        logic [ROW_W-1:0]  row;
        logic [7:0]        bdata;
        logic              bwe;

        assign ofs   = 2'(b) - addr[1:0];
        assign baddr = addr + {{(MEM_AW-2){1'b0}}, ofs};
        assign row   = baddr[MEM_AW-1:2];
        assign bdata = wdata[8*ofs +: 8];
        assign bwe   = ctl.wr_en && (ctl.word || (ofs == 2'd0));

        always_ff @(posedge aclk) begin
            if (bwe) begin
                bank_mem[row] <= bdata;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.rd_en) begin
                q_reg <= bank_mem[row];
            end
        end

        assign bank_rd[b] = q_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            lane_reg <= addr[1:0];
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_rot
        assign rdata[8*k +: 8] = bank_rd[2'(lane_reg + 2'(k))];
    end

endmodule

`default_nettype wire

FILE: rtl/msis_regfile.sv
`default_nettype none

module msis_regfile
    import msis_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire rf_ctl_t     ctl,
    input  wire logic [4:0]  raddr_a,
    input  wire logic [4:0]  raddr_b,
    input  wire logic [4:0]  waddr,
    input  wire logic [31:0] wdata,
    output logic      [31:0] rdata_a,
    output logic      [31:0] rdata_b
);

    logic [31:0] rf_mem [32];
    logic [31:0] valid_reg;
    logic [31:0] q_a_reg;
    logic [31:0] q_b_reg;
    logic        va_reg;
    logic        vb_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            rf_mem[waddr] <= wdata;
        end
        if (ctl.re) begin
            q_a_reg <= rf_mem[raddr_a];
            q_b_reg <= rf_mem[raddr_b];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end else begin
            if (ctl.we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (ctl.re) begin
                va_reg <= valid_reg[raddr_a];
                vb_reg <= valid_reg[raddr_b];
            end
        end
    end

    assign rdata_a = va_reg ? q_a_reg : '0;
    assign rdata_b = vb_reg ? q_b_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/mips_subset_instruction_step.sv
`default_nettype none
// Channel  | Ports                                              | Direction
// ---------+----------------------------------------------------+----------
// input    | s_valid s_ready s_func s_address s_write_value     | in
// result   | m_valid m_ready m_pc_after m_instr_word m_read_value | out
//
// An execute item steps through fetch from the byte memory, register read and execute;
// lw adds a second byte memory read. Byte and register reads issue and then read back;
// writes and set-pc finish at issue. The next item is taken in an item's last cycle.
// Reset is synchronous; the register file reads zero at once, byte memory is not cleared.
// A result not yet taken holds the item in flight at its last step; one result waits
// in the output register while the next item is worked on.

`include "mips_subset_instruction_step_macros.svh"

module mips_subset_instruction_step
    import msis_pkg::*;
#(
    parameter int unsigned MEM_AW = MSIS_MEM_AW
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [11:0] s_address,
    input  wire logic [31:0] s_write_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_pc_after,
    output logic      [31:0] m_instr_word,
    output logic      [31:0] m_read_value
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_EXE   = 3'd3;
    localparam logic [2:0] S_LWB   = 3'd4;
    localparam logic [2:0] S_RDB   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  func_reg;
    logic [11:0] addr_reg;
    logic [31:0] wval_reg;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] instr_reg, instr_next;
    logic        m_valid_reg;
    logic [31:0] m_pc_after_reg;
    logic [31:0] m_instr_word_reg;
    logic [31:0] m_read_value_reg;

    logic        out_free;
    logic        finish;
    logic        fire;
    logic        accept;
    logic [31:0] res_pc;
    logic [31:0] res_instr;
    logic [31:0] res_read;

    mem_ctl_t          mem_ctl;
    logic [MEM_AW-1:0] mem_addr;
    logic [31:0]       mem_wdata;
    logic [31:0]       mem_rdata;

    rf_ctl_t     rf_ctl;
    logic [4:0]  rf_raddr_a;
    logic [4:0]  rf_raddr_b;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic [31:0] rf_a;
    logic [31:0] rf_b;

    logic [31:0] item_addr32;
    logic [5:0]  op;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  shamt;
    logic [5:0]  fn;
    logic [31:0] simm;
    logic [31:0] pc_plus4;
    logic [31:0] ea;
    logic [31:0] pc_exe;
    logic [31:0] alu_res;
    logic        alu_ok;

    msis_bytemem #(
        .MEM_AW (MEM_AW)
    ) u_bytemem (
        .aclk  (aclk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    msis_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (rf_ctl),
        .raddr_a (rf_raddr_a),
        .raddr_b (rf_raddr_b),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .rdata_a (rf_a),
        .rdata_b (rf_b)
    );

    assign item_addr32 = {20'd0, addr_reg};
    assign op          = instr_reg[31:26];
    assign rt          = instr_reg[20:16];
    assign rd          = instr_reg[15:11];
    assign shamt       = instr_reg[10:6];
    assign fn          = instr_reg[5:0];
    assign simm        = {{16{instr_reg[15]}}, instr_reg[15:0]};
    assign pc_plus4    = pc_reg + 32'd4;
    assign ea          = rf_a + simm;

    always_comb begin
        alu_ok  = 1'b1;
        alu_res = '0;
        case (fn)
            FN_ADD:  alu_res = rf_a + rf_b;
            FN_SUB:  alu_res = rf_a - rf_b;
            FN_AND:  alu_res = rf_a & rf_b;
            FN_OR:   alu_res = rf_a | rf_b;
            FN_SLT:  alu_res = {31'd0, $signed(rf_a) < $signed(rf_b)};
            default: alu_ok  = 1'b0;
        endcase
    end

    always_comb begin
        pc_exe = pc_plus4;
        if (op == OP_BEQ && rf_a == rf_b) begin
            pc_exe = pc_plus4 + {simm[29:0], 2'b00};
        end else if (op == OP_J) begin
            pc_exe = {pc_plus4[31:28], instr_reg[25:0], 2'b00};
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        finish     = 1'b0;
        res_pc     = pc_reg;
        res_instr  = '0;
        res_read   = '0;
        pc_next    = pc_reg;
        instr_next = instr_reg;
        mem_ctl    = '0;
        mem_addr   = pc_reg[MEM_AW-1:0];
        mem_wdata  = rf_b;
        rf_ctl     = '0;
        rf_raddr_a = addr_reg[4:0];
        rf_raddr_b = rt;
        rf_waddr   = rt;
        rf_wdata   = ea;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
            end
            S_ISSUE: begin
                case (func_reg)
                    FUNC_EXEC: begin
                        mem_ctl.rd_en = 1'b1;
                        mem_ctl.word  = 1'b1;
                        state_next    = S_DEC;
                    end
                    FUNC_WR_MEM: begin
                        finish        = 1'b1;
                        mem_ctl.wr_en = out_free;
                        mem_addr      = item_addr32[MEM_AW-1:0];
                        mem_wdata     = {24'd0, wval_reg[7:0]};
                    end
                    FUNC_RD_MEM: begin
                        mem_ctl.rd_en = 1'b1;
                        mem_addr      = item_addr32[MEM_AW-1:0];
                        state_next    = S_RDB;
                    end
                    FUNC_WR_REG: begin
                        finish    = 1'b1;
                        rf_ctl.we = out_free && (addr_reg[4:0] != 5'd0);
                        rf_waddr  = addr_reg[4:0];
                        rf_wdata  = wval_reg;
                    end
                    FUNC_RD_REG: begin
                        rf_ctl.re  = 1'b1;
                        state_next = S_RDB;
                    end
                    FUNC_SET_PC: begin
                        finish = 1'b1;
                        res_pc = wval_reg;
                        if (out_free) begin
                            pc_next = wval_reg;
                        end
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
            end
            S_DEC: begin
                instr_next = mem_rdata;
                rf_ctl.re  = 1'b1;
                rf_raddr_a = mem_rdata[25:21];
                rf_raddr_b = mem_rdata[20:16];
                state_next = S_EXE;
            end
            S_EXE: begin
                res_instr = instr_reg;
                mem_addr  = ea[MEM_AW-1:0];
                if (op == OP_LW) begin
                    mem_ctl.rd_en = 1'b1;
                    mem_ctl.word  = 1'b1;
                    state_next    = S_LWB;
                end else begin
                    finish = 1'b1;
                    res_pc = pc_exe;
                    if (out_free) begin
                        pc_next = pc_exe;
                    end
                    if (op == OP_RTYPE) begin
                        rf_waddr  = rd;
                        rf_wdata  = alu_res;
                        rf_ctl.we = out_free && alu_ok && (shamt == 5'd0) && (rd != 5'd0);
                    end else if (op == OP_ADDI) begin
                        rf_ctl.we = out_free && (rt != 5'd0);
                    end else if (op == OP_SW) begin
                        mem_ctl.wr_en = out_free;
                        mem_ctl.word  = 1'b1;
                    end
                end
            end
            S_LWB: begin
                finish    = 1'b1;
                res_instr = instr_reg;
                res_pc    = pc_plus4;
                rf_wdata  = mem_rdata;
                rf_ctl.we = out_free && (rt != 5'd0);
                if (out_free) begin
                    pc_next = pc_plus4;
                end
            end
            S_RDB: begin
                finish   = 1'b1;
                res_read = (func_reg == FUNC_RD_MEM) ? {24'd0, mem_rdata[7:0]} : rf_a;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (accept) begin
            state_next = S_ISSUE;
        end else if (finish && out_free) begin
            state_next = S_IDLE;
        end
    end

    assign fire    = finish && out_free;
    assign s_ready = (state_reg == S_IDLE) || fire;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        instr_reg <= instr_next;
        if (accept) begin
            func_reg <= s_func;
            addr_reg <= s_address;
            wval_reg <= s_write_value;
        end
        if (fire) begin
            m_pc_after_reg   <= res_pc;
            m_instr_word_reg <= res_instr;
            m_read_value_reg <= res_read;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pc_after   = m_pc_after_reg;
    assign m_instr_word = m_instr_word_reg;
    assign m_read_value = m_read_value_reg;

    `MSIS_ASSERT_NXT(a_accept_issues, aclk, aresetn, accept, state_reg == S_ISSUE, "accepted item did not enter issue")
    `MSIS_ASSERT_IMP(a_rf_no_overlap, aclk, aresetn, rf_ctl.we, !rf_ctl.re, "register file read and write in one cycle")
    `MSIS_ASSERT_IMP(a_mem_no_overlap, aclk, aresetn, mem_ctl.wr_en, !mem_ctl.rd_en, "byte memory read and write in one cycle")
    `MSIS_ASSERT_IMP(a_no_reg0_write, aclk, aresetn, rf_ctl.we, rf_waddr != 5'd0, "write to register zero")

endmodule

`default_nettype wire

FILE: tb/mips_subset_instruction_step_tb.sv
module mips_subset_instruction_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msis_pkg::*;

    localparam int unsigned MEM_SIZE       = 1 << MSIS_MEM_AW;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned DRAIN_CYCLES   = 20;

    // Item kinds the core decodes as doing nothing.
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    typedef struct packed {
        logic [31:0] pc_after;
        logic [31:0] instr_word;
        logic [31:0] read_value;
    } step_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_func;
    logic [11:0] s_address;
    logic [31:0] s_write_value;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_pc_after;
    logic [31:0] m_instr_word;
    logic [31:0] m_read_value;

    // Shadow copy of the core's architectural state.
    logic [31:0] shadow_pc;
    logic [31:0] shadow_regs [32];
    logic [7:0]  shadow_mem [MEM_SIZE];
    bit          mem_written [MEM_SIZE];
    logic [MSIS_MEM_AW-1:0] written_addrs [$];

    step_result_t step_results_due [$];
    step_result_t head;
    int unsigned  items_sent;
    int unsigned  mismatches;
    int unsigned  quiet_cycles;
    int unsigned  hold_left;
    int unsigned  stall_left;
    bit           hold_request;
    bit           idle_en;

    mips_subset_instruction_step uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_address     (s_address),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pc_after    (m_pc_after),
        .m_instr_word  (m_instr_word),
        .m_read_value  (m_read_value)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [MSIS_MEM_AW-1:0] mem_idx(input logic [31:0] a);
        return a[MSIS_MEM_AW-1:0];
    endfunction

    function automatic logic [31:0] shadow_word(input logic [31:0] base);
        logic [31:0] w;
        int k;
        for (k = 0; k < 4; k++) w[8*k +: 8] = shadow_mem[mem_idx(base + 32'(k))];
        return w;
    endfunction

    function automatic void shadow_reg_write(input logic [4:0] idx, input logic [31:0] val);
        if (idx != 5'd0) shadow_regs[idx] = val;
    endfunction

    function automatic void note_byte_write(input logic [MSIS_MEM_AW-1:0] idx,
                                            input logic [7:0] b);
        if (!mem_written[idx]) written_addrs.push_back(idx);
        mem_written[idx] = 1'b1;
        shadow_mem[idx] = b;
    endfunction

    // Applies one item to the shadow core and returns the result it must produce.
    function automatic step_result_t shadow_step(input logic [2:0] f, input logic [11:0] a,
                                                 input logic [31:0] v);
        step_result_t r;
        logic [31:0]  ins, op_a, op_b, simm, nxt, ea, alu;
        logic [5:0]   op, fn;
        logic [4:0]   rs, rt, rd, sh;
        logic         wr;
        int           k;
        r = '0;
        wr = 1'b0;
        alu = '0;
        case (f)
            FUNC_EXEC: begin
                ins  = shadow_word(shadow_pc);
                op   = ins[31:26];
                rs   = ins[25:21];
                rt   = ins[20:16];
                rd   = ins[15:11];
                sh   = ins[10:6];
                fn   = ins[5:0];
                simm = {{16{ins[15]}}, ins[15:0]};
                op_a = shadow_regs[rs];
                op_b = shadow_regs[rt];
                nxt  = shadow_pc + 32'd4;
                case (op)
                    OP_RTYPE: begin
                        if (sh == 5'd0) begin
                            wr = 1'b1;
                            case (fn)
                                FN_ADD:  alu = op_a + op_b;
                                FN_SUB:  alu = op_a - op_b;
                                FN_AND:  alu = op_a & op_b;
                                FN_OR:   alu = op_a | op_b;
                                FN_SLT:  alu = {31'd0, $signed(op_a) < $signed(op_b)};
                                default: wr = 1'b0;
                            endcase
                            if (wr) shadow_reg_write(rd, alu);
                        end
                    end
                    OP_BEQ: begin
                        if (op_a == op_b) nxt = nxt + {simm[29:0], 2'b00};
                    end
                    OP_ADDI: shadow_reg_write(rt, op_a + simm);
                    OP_LW:   shadow_reg_write(rt, shadow_word(op_a + simm));
                    OP_SW: begin
                        ea = op_a + simm;
                        for (k = 0; k < 4; k++) note_byte_write(mem_idx(ea + 32'(k)), op_b[8*k +: 8]);
                    end
                    OP_J:    nxt = {nxt[31:28], ins[25:0], 2'b00};
                    default: ;
                endcase
                shadow_pc = nxt;
                r.instr_word = ins;
            end
            FUNC_WR_MEM: note_byte_write(mem_idx(32'(a)), v[7:0]);
            FUNC_RD_MEM: r.read_value = {24'd0, shadow_mem[mem_idx(32'(a))]};
            FUNC_WR_REG: shadow_reg_write(a[4:0], v);
            FUNC_RD_REG: r.read_value = shadow_regs[a[4:0]];
            FUNC_SET_PC: shadow_pc = v;
            default: ;
        endcase
        r.pc_after = shadow_pc;
        return r;
    endfunction

    function automatic logic [31:0] rtype_word(input logic [4:0] rs, input logic [4:0] rt,
                                               input logic [4:0] rd, input logic [4:0] sh,
                                               input logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    // Mostly a handful of low registers, so that results feed later instructions.
    function automatic logic [4:0] random_reg();
        if ($urandom_range(0, 3) == 0) return 5'($urandom);
        return 5'($urandom_range(0, 7));
    endfunction

    function automatic logic [31:0] seed_value();
        case ($urandom_range(0, 7))
            0, 1, 2: return 32'($urandom_range(0, 4095));
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return 32'h7FFF_FFFF;
            6:       return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_instruction();
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, sh;
        logic [15:0] imm;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if ($urandom_range(0, 2) == 0) imm = 16'($urandom);
        else imm = 16'($urandom_range(0, 32)) - 16'd16;
        rs = random_reg();
        rt = ($urandom_range(0, 2) == 0) ? rs : random_reg();
        sh = 5'd0;
        if (pick < 9) begin
            case ($urandom_range(0, 4))
                0:       fn = FN_ADD;
                1:       fn = FN_SUB;
                2:       fn = FN_AND;
                3:       fn = FN_OR;
                default: fn = FN_SLT;
            endcase
            // A nonzero shift amount turns the R-type into a no-op.
            if ($urandom_range(0, 15) == 0) sh = 5'($urandom_range(1, 31));
            return rtype_word(rs, rt, random_reg(), sh, fn);
        end
        if (pick == 9) begin
            fn = 6'($urandom);
            while (fn == FN_ADD || fn == FN_SUB || fn == FN_AND || fn == FN_OR || fn == FN_SLT)
                fn = 6'($urandom);
            return rtype_word(rs, rt, random_reg(), sh, fn);
        end
        if (pick < 12) op = OP_BEQ;
        else if (pick < 14) op = OP_ADDI;
        else if (pick < 16) op = OP_LW;
        else if (pick < 18) op = OP_SW;
        else if (pick == 18) return {OP_J, 26'($urandom)};
        else begin
            op = 6'($urandom);
            while (op == OP_RTYPE || op == OP_J || op == OP_BEQ || op == OP_ADDI ||
                   op == OP_LW || op == OP_SW)
                op = 6'($urandom);
            return {op, 26'($urandom)};
        end
        return {op, rs, rt, imm};
    endfunction

    // Offers one item, waits until it is taken, then queues the result it must produce.
    task automatic send_item(input logic [2:0] f, input logic [11:0] a, input logic [31:0] v);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= f;
        s_address     <= a;
        s_write_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        step_results_due.push_back(shadow_step(f, a, v));
        items_sent++;
    endtask

    task automatic store_word_items(input logic [11:0] base, input logic [31:0] word);
        int k;
        for (k = 0; k < 4; k++)
            send_item(FUNC_WR_MEM, base + 12'(k), {24'hFF_FFFF, word[8*k +: 8]});
    endtask

    // Fills in any unwritten bytes the next instruction will read, then executes it.
    task automatic exec_one();
        logic [31:0] fresh, ins, ea, byte_addr;
        int k;
        fresh = random_instruction();
        for (k = 0; k < 4; k++) begin
            byte_addr = shadow_pc + 32'(k);
            if (!mem_written[mem_idx(byte_addr)])
                send_item(FUNC_WR_MEM, 12'(mem_idx(byte_addr)), {24'($urandom), fresh[8*k +: 8]});
        end
        ins = shadow_word(shadow_pc);
        if (ins[31:26] == OP_LW) begin
            ea = shadow_regs[ins[25:21]] + {{16{ins[15]}}, ins[15:0]};
            for (k = 0; k < 4; k++) begin
                byte_addr = ea + 32'(k);
                if (!mem_written[mem_idx(byte_addr)])
                    send_item(FUNC_WR_MEM, 12'(mem_idx(byte_addr)), $urandom);
            end
        end
        send_item(FUNC_EXEC, 12'($urandom), $urandom);
    endtask

    task automatic send_noise_item();
        logic [4:0] r;
        r = random_reg();
        case ($urandom_range(0, 5))
            0: send_item(FUNC_RD_REG, {7'($urandom), r}, $urandom);
            1: send_item(FUNC_WR_REG, {7'($urandom), r}, seed_value());
            2: begin
                if (written_addrs.size() != 0)
                    send_item(FUNC_RD_MEM,
                              12'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]),
                              $urandom);
            end
            3: send_item(FUNC_WR_MEM, 12'($urandom), $urandom);
            4: send_item(($urandom_range(0, 1) != 0) ? FUNC_RSVD7 : FUNC_RSVD6,
                         12'($urandom), $urandom);
            default: send_item(FUNC_SET_PC, 12'($urandom), $urandom);
        endcase
    endtask

    // Short programs from a random start, each run once or twice with the registers it left.
    task automatic run_programs(input int unsigned target, input bit allow_idle);
        logic [31:0] base;
        int unsigned runs;
        while (items_sent < target) begin
            idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) base = $urandom;
            else base = 32'($urandom_range(0, 4095));
            repeat ($urandom_range(0, 3))
                send_item(FUNC_WR_REG, {7'($urandom), random_reg()}, seed_value());
            runs = $urandom_range(1, 2);
            repeat (runs) begin
                send_item(FUNC_SET_PC, 12'($urandom), base);
                repeat ($urandom_range(4, 16)) begin
                    if ($urandom_range(0, 7) == 0) send_noise_item();
                    exec_one();
                end
            end
        end
    endtask

    task automatic test_register_items();
        send_item(FUNC_RD_REG, 12'hFFF, 32'h0);
        // Only the low five address bits select the register, so this hits register zero.
        send_item(FUNC_WR_REG, 12'hFE0, 32'hFFFF_FFFF);
        send_item(FUNC_RD_REG, 12'h000, 32'hFFFF_FFFF);
        send_item(FUNC_WR_REG, 12'h01F, 32'hFFFF_FFFF);
        send_item(FUNC_WR_REG, 12'h802, 32'h8000_0000);
        send_item(FUNC_RD_REG, 12'hFFF, 32'h0);
    endtask

    // The first instruction straddles the top of memory and the PC wraps past 2**32.
    task automatic test_fetch_wrap();
        send_item(FUNC_SET_PC, 12'h000, 32'hFFFF_FFFE);
        store_word_items(12'hFFE, rtype_word(5'd31, 5'd31, 5'd1, 5'd0, FN_ADD));
        send_item(FUNC_EXEC, 12'hFFF, 32'hFFFF_FFFF);
        send_item(FUNC_RD_REG, 12'h001, 32'h0);
        store_word_items(12'h002, rtype_word(5'd2, 5'd31, 5'd3, 5'd0, FN_SLT));
        send_item(FUNC_EXEC, 12'h000, 32'h0);
        send_item(FUNC_RD_REG, 12'hFE3, 32'h0);
        send_item(FUNC_RD_MEM, 12'hFFF, 32'h0);
        send_item(FUNC_RD_MEM, 12'h000, 32'hFFFF_FFFF);
    endtask

    task automatic test_unused_func_codes();
        send_item(FUNC_RSVD6, 12'($urandom), $urandom);
        send_item(FUNC_RSVD7, 12'($urandom), $urandom);
        send_item(FUNC_SET_PC, 12'hFFF, 32'h0);
    endtask

    task automatic test_programs_with_idling();
        run_programs(1320, 1'b1);
    endtask

    // The sink stops for a long stretch while the source keeps offering items.
    task automatic test_result_backpressure();
        idle_en = 1'b0;
        hold_request = 1'b1;
        repeat (24) exec_one();
    endtask

    task automatic test_programs_back_to_back();
        idle_en = 1'b0;
        run_programs(items_sent + 200, 1'b0);
    endtask

    // Result sink: random stall bursts, plus one long hold on request.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (step_results_due.size() == 0) begin
                $error("unexpected result item: pc_after %h instr_word %h read_value %h",
                       m_pc_after, m_instr_word, m_read_value);
                mismatches++;
            end else begin
                head = step_results_due.pop_front();
                if (m_pc_after !== head.pc_after) begin
                    $error("pc_after: expected %h, actual %h", head.pc_after, m_pc_after);
                    mismatches++;
                end
                if (m_instr_word !== head.instr_word) begin
                    $error("instr_word: expected %h, actual %h", head.instr_word, m_instr_word);
                    mismatches++;
                end
                if (m_read_value !== head.read_value) begin
                    $error("read_value: expected %h, actual %h", head.read_value, m_read_value);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        shadow_pc = '0;
        for (int i = 0; i < 32; i++) shadow_regs[i] = '0;
        for (int i = 0; i < MEM_SIZE; i++) begin
            shadow_mem[i] = '0;
            mem_written[i] = 1'b0;
        end
        items_sent    = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        hold_left     = 0;
        stall_left    = 0;
        hold_request  = 1'b0;
        idle_en       = 1'b1;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_func        <= FUNC_EXEC;
        s_address     <= '0;
        s_write_value <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_register_items();
        test_fetch_wrap();
        test_unused_func_codes();
        test_programs_with_idling();
        test_result_backpressure();
        test_programs_back_to_back();

        s_valid <= 1'b0;
        while (step_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/msis_pkg.sv
rtl/msis_bytemem.sv
rtl/msis_regfile.sv
rtl/mips_subset_instruction_step.sv
tb/mips_subset_instruction_step_tb.sv
